// ===== rtl/fnl_pkg.sv =====
// Package for the configuration nibble loader: request and outcome codes,
// command type passed from front to back, pin masks and the nibble reverse.
// No dependencies.
package fnl_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DATA  = 2'd1;
  localparam logic [1:0] REQ_POLL  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_INIT_LIMIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DONE_LIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CONFIRM    = 2'd2;

  localparam logic [7:0] INIT_LIMIT_RST = 8'd10;
  localparam logic [9:0] DONE_LIMIT_RST = 10'd100;
  localparam logic [7:0] CONFIRM_RST    = 8'd10;

  localparam logic [1:0] OUT_BUSY      = 2'd0;
  localparam logic [1:0] OUT_OK        = 2'd1;
  localparam logic [1:0] OUT_INIT_TO   = 2'd2;
  localparam logic [1:0] OUT_DONE_FAIL = 2'd3;

  // pin word: [3:0] data, [4] clock, [5] chip select, [6] program control
  localparam logic [6:0] PIN_CS_M = 7'h20;
  localparam logic [6:0] PIN_PB_M = 7'h40;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_TIMEOUT,
    CMD_FINISH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic [1:0] outcome;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] rev4(input logic [3:0] n);
    rev4 = {n[0], n[1], n[2], n[3]};
  endfunction

endpackage

// ===== rtl/fnl_if.sv =====
// Request and result channel interfaces of the nibble loader.
// No dependencies.
interface fnl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       data_last;
  logic       init_b;
  logic       done_in;

  modport source (output valid, req_type, data_byte, data_last, init_b, done_in,
                  input ready);
  modport sink (input valid, req_type, data_byte, data_last, init_b, done_in,
                output ready);
endinterface

interface fnl_res_if;
  logic       valid;
  logic       ready;
  logic       ctrl_write;
  logic       chip_select;
  logic       prog_ctl;
  logic [3:0] cfg_data;
  logic       cfg_clock;
  logic [1:0] outcome;
  logic       run_last;

  modport source (output valid, ctrl_write, chip_select, prog_ctl, cfg_data,
                  cfg_clock, outcome, run_last, input ready);
  modport sink (input valid, ctrl_write, chip_select, prog_ctl, cfg_data,
                cfg_clock, outcome, run_last, output ready);
endinterface

// ===== rtl/fnl_front.sv =====
// Front end: accepts request beats, runs the phase and poll counters,
// holds the limit registers and issues commands. Uses fnl_pkg, fnl_if.
module fnl_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fnl_req_if.sink                      req_i,
  input  logic                         cfg_we_i,
  input  logic [fnl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fnl_pkg::CfgDataW-1:0] cfg_data_i,
  input  fnl_pkg::q_stat_t             stat_i,
  output logic                         push_o,
  output fnl_pkg::cmd_t                cmd_o
);
  import fnl_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_WINIT     = 3'd1;
  localparam logic [2:0] PH_WINIT_E   = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_WDONE     = 3'd4;
  localparam logic [2:0] PH_CONFIRM   = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [9:0] poll_q, poll_d, poll_inc;
  logic [7:0] conf_q, conf_d, conf_inc;
  logic [7:0] init_lim_q, conf_lim_q, init_lim, conf_lim;
  logic [9:0] done_lim_q, done_lim;
  logic       acc;

  assign req_i.ready = !stat_i.full;
  assign acc         = req_i.valid && req_i.ready;
  assign poll_inc    = poll_q + 10'd1;
  assign conf_inc    = conf_q + 8'd1;
  assign init_lim    = (init_lim_q == '0) ? 8'd1 : init_lim_q;
  assign done_lim    = (done_lim_q == '0) ? 10'd1 : done_lim_q;
  assign conf_lim    = (conf_lim_q == '0) ? 8'd1 : conf_lim_q;

  always_comb begin
    phase_d = phase_q;
    poll_d  = poll_q;
    conf_d  = conf_q;
    push_o  = 1'b0;
    cmd_o   = '{kind: CMD_START, data: req_i.data_byte, outcome: OUT_BUSY};
    if (acc) begin
      unique case (req_i.req_type)
        REQ_START: begin
          push_o  = 1'b1;
          phase_d = req_i.data_last ? PH_WINIT_E : PH_WINIT;
          poll_d  = '0;
          conf_d  = '0;
        end
        REQ_DATA: begin
          if (phase_q == PH_DATA) begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_DATA;
            if (req_i.data_last) begin
              phase_d = PH_WDONE;
              poll_d  = '0;
            end
          end
        end
        REQ_POLL: begin
          unique case (phase_q)
            PH_WINIT, PH_WINIT_E: begin
              if (req_i.init_b) begin
                phase_d = (phase_q == PH_WINIT_E) ? PH_WDONE : PH_DATA;
                poll_d  = '0;
              end else if (poll_inc >= {2'b00, init_lim}) begin
                phase_d       = PH_IDLE;
                poll_d        = '0;
                push_o        = 1'b1;
                cmd_o.kind    = CMD_TIMEOUT;
                cmd_o.outcome = OUT_INIT_TO;
              end else begin
                poll_d = poll_inc;
              end
            end
            PH_WDONE: begin
              poll_d = poll_inc;
              if (req_i.done_in || poll_inc >= done_lim) begin
                phase_d = PH_CONFIRM;
                conf_d  = '0;
              end
            end
            PH_CONFIRM: begin
              if (req_i.done_in && conf_inc < conf_lim) begin
                conf_d = conf_inc;
              end else begin
                phase_d       = PH_IDLE;
                poll_d        = '0;
                conf_d        = '0;
                push_o        = 1'b1;
                cmd_o.kind    = CMD_FINISH;
                cmd_o.outcome = req_i.done_in ? OUT_OK : OUT_DONE_FAIL;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      poll_q  <= '0;
      conf_q  <= '0;
    end else begin
      phase_q <= phase_d;
      poll_q  <= poll_d;
      conf_q  <= conf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_lim_q <= INIT_LIMIT_RST;
      done_lim_q <= DONE_LIMIT_RST;
      conf_lim_q <= CONFIRM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INIT_LIMIT: init_lim_q <= cfg_data_i[7:0];
        CFG_DONE_LIMIT: done_lim_q <= cfg_data_i[9:0];
        CFG_CONFIRM:    conf_lim_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/fnl_cmd_fifo.sv =====
// Short command queue between front and back ends.
// Uses fnl_pkg.
module fnl_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fnl_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output fnl_pkg::cmd_t    head_o,
  output fnl_pkg::q_stat_t stat_o
);
  import fnl_pkg::*;

  localparam logic [QPtrW-1:0] PtrLast = QPtrW'(QDepth - 1);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;

  assign head_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/fnl_back.sv =====
// Back end: expands queued commands into pin-state beats, tracks the pin
// word and holds the result output register. Uses fnl_pkg, fnl_if.
module fnl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fnl_pkg::cmd_t    cmd_i,
  input  fnl_pkg::q_stat_t stat_i,
  output logic             pop_o,
  fnl_res_if.source        res_o
);
  import fnl_pkg::*;

  logic [6:0] pin_q, beat_pin, out_pin_q;
  logic [1:0] cnt_q;
  logic       beat_ctrl, beat_last, load;
  logic       ov_q, ctrl_q, last_q;
  logic [1:0] outcome_q;
  logic [1:0] ctl;
  logic [3:0] hi_n, lo_n;

  assign ctl  = pin_q[6:5];
  assign hi_n = rev4(cmd_i.data[7:4]);
  assign lo_n = rev4(cmd_i.data[3:0]);

  always_comb begin
    beat_pin  = pin_q;
    beat_ctrl = 1'b0;
    beat_last = 1'b1;
    unique case (cmd_i.kind)
      CMD_START: begin
        beat_ctrl = 1'b1;
        beat_last = (cnt_q == 2'd2);
        unique case (cnt_q)
          2'd0:    beat_pin = '0;
          2'd1:    beat_pin = PIN_CS_M;
          default: beat_pin = PIN_CS_M | PIN_PB_M;
        endcase
      end
      CMD_DATA: begin
        beat_last = (cnt_q == 2'd3);
        unique case (cnt_q)
          2'd0:    beat_pin = {ctl, 1'b0, hi_n};
          2'd1:    beat_pin = {ctl, 1'b1, hi_n};
          2'd2:    beat_pin = {ctl, 1'b1, lo_n};
          default: beat_pin = {ctl, 1'b0, lo_n};
        endcase
      end
      CMD_TIMEOUT: beat_pin = pin_q;
      CMD_FINISH: begin
        beat_ctrl = 1'b1;
        beat_pin  = {2'b10, pin_q[4:0]};
      end
      default: ;
    endcase
  end

  assign load  = !stat_i.empty && (!ov_q || res_o.ready);
  assign pop_o = load && beat_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        pin_q <= beat_pin;
        cnt_q <= beat_last ? 2'd0 : cnt_q + 2'd1;
        ov_q  <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pin_q <= beat_pin;
      ctrl_q    <= beat_ctrl;
      outcome_q <= cmd_i.outcome;
      last_q    <= beat_last;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.ctrl_write  = ctrl_q;
  assign res_o.chip_select = out_pin_q[5];
  assign res_o.prog_ctl    = out_pin_q[6];
  assign res_o.cfg_data    = out_pin_q[3:0];
  assign res_o.cfg_clock   = out_pin_q[4];
  assign res_o.outcome     = outcome_q;
  assign res_o.run_last    = last_q;

`ifndef ASSERT_OFF
  a_mid_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd0 |-> !stat_i.empty) else $error("command left mid expansion");
  a_fourth_beat_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd3 |-> cmd_i.kind == CMD_DATA) else $error("beat count overrun");
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !last_q |-> outcome_q == OUT_BUSY) else $error("outcome before last beat");
`endif

endmodule

// ===== rtl/fpga_config_nibble_loader_unit.sv =====
// Top level of the configuration nibble loader: front end, command queue
// and back end. Uses fnl_pkg, fnl_if, fnl_front, fnl_cmd_fifo, fnl_back.
//
//  port        dir  beat contents
//  req_i       in   req_type, data_byte, data_last, init_b, done_in
//  res_o       out  ctrl_write, chip_select, prog_ctl, cfg_data, cfg_clock,
//                   outcome, run_last
//  cfg_*_i     in   limit register writes, no handshake
//
// Output beats leave one per cycle while the result side is ready: a data
// byte gives four beats, a start three, a timeout or finish one; polls that only advance a wait give none.
// The front takes a request each cycle while the 2-entry queue has room.
// Output register separates the result stall from the request side.
// Reset is asynchronous, active low; no clearing pass.
module fpga_config_nibble_loader_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fnl_req_if.sink                      req_i,
  fnl_res_if.source                    res_o,
  input  logic                         cfg_we_i,
  input  logic [fnl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fnl_pkg::CfgDataW-1:0] cfg_data_i
);
  import fnl_pkg::*;

  cmd_t    cmd_in, cmd_head;
  q_stat_t q_stat;
  logic    push, pop;

  fnl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (q_stat),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  fnl_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .head_o (cmd_head),
    .stat_o (q_stat)
  );

  fnl_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

// ===== test/fpga_config_nibble_loader_unit_test.sv =====
// Testbench for fpga_config_nibble_loader_unit: directed runs, then random configuration runs
// checked beat by beat against a built-in predictor of the loader.
// Depends on fnl_pkg, fnl_if and the loader RTL.
`timescale 1ns / 1ps

module fpga_config_nibble_loader_unit_test;
  import fnl_pkg::*;

  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam int         SETTLE       = 16;
  localparam int         STUCK_LIMIT  = 4000;
  localparam int         RANDOM_ITEMS = 450;

  typedef enum logic [2:0] {
    LD_IDLE,
    LD_WAIT_INIT,
    LD_WAIT_INIT_EMPTY,
    LD_DATA,
    LD_WAIT_DONE,
    LD_CONFIRM
  } load_phase_e;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic       ctrl_write;
    logic       chip_select;
    logic       prog_ctl;
    logic [3:0] cfg_data;
    logic       cfg_clock;
    logic [1:0] outcome;
    logic       run_last;
  } pin_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  fnl_req_if req_ch ();
  fnl_res_if res_ch ();

  fpga_config_nibble_loader_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // predictor state
  logic [7:0]  init_limit;
  logic [9:0]  done_limit;
  logic [7:0]  confirm_need;
  load_phase_e load_phase;
  logic [9:0]  poll_cnt;
  logic [7:0]  confirm_cnt;
  logic [6:0]  pins;

  pin_beat_t expected_pins[$];
  int        errors;
  int        effective_items;
  int        burst_left;
  int        beat_no;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [3:0] swap_nibble(input logic [3:0] n);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) r[3-i] = n[i];
    return r;
  endfunction

  function automatic logic [9:0] floor_one(input logic [9:0] v);
    return (v == '0) ? 10'd1 : v;
  endfunction

  function automatic void push_beat(input logic ctrl, input logic [1:0] oc, input logic last);
    expected_pins.push_back('{ctrl, pins[5], pins[6], pins[3:0], pins[4], oc, last});
  endfunction

  // returns 1 when the item is acted on rather than ignored
  function automatic bit advance_loader(input logic [1:0] rq, input logic [7:0] byte_v,
                                        input logic last, input logic ib, input logic dn);
    logic [6:0] ctl;
    logic [1:0] oc;
    case (rq)
      REQ_START: begin
        pins = '0;
        push_beat(1'b1, OUT_BUSY, 1'b0);
        pins = PIN_CS_M;
        push_beat(1'b1, OUT_BUSY, 1'b0);
        pins = PIN_CS_M | PIN_PB_M;
        push_beat(1'b1, OUT_BUSY, 1'b1);
        load_phase  = last ? LD_WAIT_INIT_EMPTY : LD_WAIT_INIT;
        poll_cnt    = '0;
        confirm_cnt = '0;
        return 1'b1;
      end
      REQ_DATA: begin
        if (load_phase != LD_DATA) return 1'b0;
        ctl  = pins & (PIN_CS_M | PIN_PB_M);
        pins = ctl | {3'b0, swap_nibble(byte_v[7:4])};
        push_beat(1'b0, OUT_BUSY, 1'b0);
        pins[4] = 1'b1;
        push_beat(1'b0, OUT_BUSY, 1'b0);
        pins = ctl | {3'b001, swap_nibble(byte_v[3:0])};
        push_beat(1'b0, OUT_BUSY, 1'b0);
        pins[4] = 1'b0;
        push_beat(1'b0, OUT_BUSY, 1'b1);
        if (last) begin
          load_phase = LD_WAIT_DONE;
          poll_cnt   = '0;
        end
        return 1'b1;
      end
      REQ_POLL: begin
        case (load_phase)
          LD_WAIT_INIT, LD_WAIT_INIT_EMPTY: begin
            poll_cnt = poll_cnt + 10'd1;
            if (ib) begin
              load_phase = (load_phase == LD_WAIT_INIT_EMPTY) ? LD_WAIT_DONE : LD_DATA;
              poll_cnt   = '0;
            end else if (poll_cnt >= floor_one({2'b0, init_limit})) begin
              load_phase = LD_IDLE;
              poll_cnt   = '0;
              push_beat(1'b0, OUT_INIT_TO, 1'b1);
            end
            return 1'b1;
          end
          LD_WAIT_DONE: begin
            poll_cnt = poll_cnt + 10'd1;
            if (dn || poll_cnt >= floor_one(done_limit)) begin
              load_phase  = LD_CONFIRM;
              confirm_cnt = '0;
            end
            return 1'b1;
          end
          LD_CONFIRM: begin
            if (dn) begin
              confirm_cnt = confirm_cnt + 8'd1;
              if ({2'b0, confirm_cnt} < floor_one({2'b0, confirm_need})) return 1'b1;
              oc = OUT_OK;
            end else begin
              oc = OUT_DONE_FAIL;
            end
            pins        = (pins & 7'h1f) | PIN_PB_M;
            load_phase  = LD_IDLE;
            poll_cnt    = '0;
            confirm_cnt = '0;
            push_beat(1'b1, oc, 1'b1);
            return 1'b1;
          end
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] rq, input logic [7:0] byte_v, input logic last,
                           input logic ib, input logic dn);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rq;
    req_ch.data_byte <= byte_v;
    req_ch.data_last <= last;
    req_ch.init_b    <= ib;
    req_ch.done_in   <= dn;
    do @(posedge clk_i); while (!(req_ch.valid && req_ch.ready));
    if (advance_loader(rq, byte_v, last, ib, dn)) effective_items++;
  endtask

  // hold off until every expected beat is out and the block has gone quiet
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_pins.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_INIT_LIMIT: init_limit   = val[7:0];
      CFG_DONE_LIMIT: done_limit   = val;
      CFG_CONFIRM:    confirm_need = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [7:0] il, input logic [9:0] dl, input logic [7:0] cr);
    drain();
    write_reg(CFG_INIT_LIMIT, {2'b0, il});
    write_reg(CFG_DONE_LIMIT, dl);
    write_reg(CFG_CONFIRM, {2'b0, cr});
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_ignored_items();
    send_item(REQ_NONE, 8'hff, 1'b1, 1'b1, 1'b1);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b1);
    send_item(REQ_DATA, 8'h3c, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_loaded_image();
    configure(8'd2, 10'd3, 8'd2);
    send_item(REQ_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(REQ_DATA, 8'h81, 1'b1, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
    send_item(REQ_DATA, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(REQ_DATA, 8'hff, 1'b0, 1'b1, 1'b1);
    send_item(REQ_DATA, 8'h5a, 1'b1, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
  endtask

  // zero limit acts as one
  task automatic test_init_timeout();
    configure(8'd0, 10'd3, 8'd2);
    send_item(REQ_START, 8'h00, 1'b0, 1'b1, 1'b1);
    send_item(REQ_POLL, 8'hff, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_empty_image();
    configure(8'd1, 10'd0, 8'd0);
    send_item(REQ_START, 8'h00, 1'b1, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_restart();
    send_item(REQ_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b1, 1'b0);
    send_item(REQ_DATA, 8'h96, 1'b0, 1'b0, 1'b0);
    send_item(REQ_START, 8'h00, 1'b0, 1'b0, 1'b0);
    send_item(REQ_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic random_run(input int p_init, input int p_done, input int p_conf,
                            input int bytes_mean);
    int guard;
    send_item(REQ_START, 8'($urandom), ($urandom_range(0, 7) == 0), 1'($urandom),
              1'($urandom));
    guard = 0;
    while (load_phase != LD_IDLE && guard < 4000) begin
      guard++;
      if ($urandom_range(0, 99) < 6) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
      end else begin
        case (load_phase)
          LD_WAIT_INIT, LD_WAIT_INIT_EMPTY:
            send_item(REQ_POLL, 8'($urandom), 1'($urandom), ($urandom_range(0, 99) < p_init),
                      1'($urandom));
          LD_DATA:
            send_item(REQ_DATA, 8'($urandom), ($urandom_range(1, bytes_mean) == 1),
                      1'($urandom), 1'($urandom));
          LD_WAIT_DONE:
            send_item(REQ_POLL, 8'($urandom), 1'($urandom), 1'($urandom),
                      ($urandom_range(0, 99) < p_done));
          default:
            send_item(REQ_POLL, 8'($urandom), 1'($urandom), 1'($urandom),
                      ($urandom_range(0, 99) < p_conf));
        endcase
      end
    end
  endtask

  task automatic test_random_runs();
    int         setting_no;
    int         p_init;
    logic [7:0] il;
    logic [9:0] dl;
    logic [7:0] cr;
    setting_no      = 0;
    effective_items = 0;
    while (effective_items < RANDOM_ITEMS) begin
      if (setting_no == 1) begin
        il = 8'd255;
        dl = 10'd1023;
        cr = 8'd255;
      end else if (setting_no == 3) begin
        il = 8'd1;
        dl = 10'd1;
        cr = 8'd1;
      end else begin
        il = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
        dl = ($urandom_range(0, 5) == 0) ? 10'd0 : 10'($urandom_range(1, 40));
        cr = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 8));
      end
      configure(il, dl, cr);
      repeat ($urandom_range(1, 4)) begin
        p_init = (setting_no == 1) ? $urandom_range(5, 20) : $urandom_range(5, 60);
        random_run(p_init, $urandom_range(5, 50),
                   (setting_no == 1 || $urandom_range(0, 2) == 0) ? 90 : 100,
                   $urandom_range(1, 10));
      end
      setting_no++;
    end
  endtask

  // result side: check accepted beats, then pick the next ready level
  initial begin
    rx_mode_e rx_mode;
    int       rx_timer;
    pin_beat_t got, want;
    res_ch.ready <= 1'b0;
    rx_mode  = RX_OPEN;
    rx_timer = 0;
    beat_no  = 0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.ctrl_write, res_ch.chip_select, res_ch.prog_ctl, res_ch.cfg_data,
                res_ch.cfg_clock, res_ch.outcome, res_ch.run_last};
        if (expected_pins.size() == 0) begin
          report_error($sformatf("beat %0d: unexpected result beat %h", beat_no, got));
        end else begin
          want = expected_pins.pop_front();
          if (got.ctrl_write !== want.ctrl_write)
            report_error($sformatf("beat %0d: ctrl_write %b, want %b", beat_no,
                                   got.ctrl_write, want.ctrl_write));
          if (got.chip_select !== want.chip_select)
            report_error($sformatf("beat %0d: chip_select %b, want %b", beat_no,
                                   got.chip_select, want.chip_select));
          if (got.prog_ctl !== want.prog_ctl)
            report_error($sformatf("beat %0d: prog_ctl %b, want %b", beat_no,
                                   got.prog_ctl, want.prog_ctl));
          if (got.cfg_data !== want.cfg_data)
            report_error($sformatf("beat %0d: cfg_data %h, want %h", beat_no,
                                   got.cfg_data, want.cfg_data));
          if (got.cfg_clock !== want.cfg_clock)
            report_error($sformatf("beat %0d: cfg_clock %b, want %b", beat_no,
                                   got.cfg_clock, want.cfg_clock));
          if (got.outcome !== want.outcome)
            report_error($sformatf("beat %0d: outcome %0d, want %0d", beat_no,
                                   got.outcome, want.outcome));
          if (got.run_last !== want.run_last)
            report_error($sformatf("beat %0d: run_last %b, want %b", beat_no,
                                   got.run_last, want.run_last));
        end
        beat_no++;
      end
      if (rx_timer == 0) begin
        rx_mode  = rx_mode_e'($urandom_range(0, 3));
        rx_timer = $urandom_range(20, 150);
      end
      rx_timer--;
      case (rx_mode)
        RX_OPEN:   res_ch.ready <= 1'b1;
        RX_COIN:   res_ch.ready <= 1'($urandom);
        RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   res_ch.ready <= ((rx_timer % 8) < 5);
      endcase
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_START;
    req_ch.data_byte <= '0;
    req_ch.data_last <= 1'b0;
    req_ch.init_b    <= 1'b0;
    req_ch.done_in   <= 1'b0;
    init_limit   = INIT_LIMIT_RST;
    done_limit   = DONE_LIMIT_RST;
    confirm_need = CONFIRM_RST;
    load_phase   = LD_IDLE;
    poll_cnt     = '0;
    confirm_cnt  = '0;
    pins         = '0;
    errors       = 0;
    burst_left   = 0;
    effective_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_items();
    test_loaded_image();
    test_init_timeout();
    test_empty_image();
    test_restart();
    test_random_runs();
    drain();

    if (expected_pins.size() != 0)
      report_error($sformatf("%0d result beats never arrived", expected_pins.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
